// ===== hw/rtl/ths_pkg.sv =====
package ths_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DRIVE_DUTY    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DWELL_TICKS   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RESTART_TICKS = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFFSET_TWO    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFFSET_ONE    = 3'd4;

   localparam logic [13:0] DUTY_MAX            = 14'd12499;
   localparam logic [13:0] DRIVE_DUTY_RESET    = 14'd999;
   localparam logic [15:0] DWELL_TICKS_RESET   = 16'd2000;
   localparam logic [15:0] RESTART_TICKS_RESET = 16'd10000;
   localparam logic [15:0] OFFSET_TWO_RESET    = 16'd100;
   localparam logic [15:0] OFFSET_ONE_RESET    = 16'd0;

   localparam logic [3:0] PH_SEEK_LEFT_TWO = 4'd0;
   localparam logic [3:0] PH_AXIS_SPAN     = 4'd6;
   localparam logic [3:0] PH_RESTART       = 4'd12;

   localparam logic [2:0] SUB_SEEK_LEFT    = 3'd0;
   localparam logic [2:0] SUB_DWELL_LEFT   = 3'd1;
   localparam logic [2:0] SUB_SEEK_RIGHT   = 3'd2;
   localparam logic [2:0] SUB_DWELL_RIGHT  = 3'd3;
   localparam logic [2:0] SUB_CENTER       = 3'd4;
   localparam logic [2:0] SUB_DWELL_CENTER = 3'd5;

   localparam logic [1:0] STEP_NONE = 2'd0;
   localparam logic [1:0] STEP_UP   = 2'd1;
   localparam logic [1:0] STEP_DOWN = 2'd2;

   typedef struct packed {
      logic enc_one_a;
      logic enc_one_b;
      logic enc_two_a;
      logic enc_two_b;
      logic sw_one_left;
      logic sw_one_right;
      logic sw_two_left;
      logic sw_two_right;
      logic ms_tick;
   } req_type;

   typedef struct packed {
      logic               bridge_one_in1;
      logic               bridge_one_in2;
      logic               bridge_two_in1;
      logic               bridge_two_in2;
      logic [13:0]        duty_one;
      logic [13:0]        duty_two;
      logic signed [31:0] count_one;
      logic signed [31:0] count_two;
      logic signed [31:0] span_one;
      logic signed [31:0] span_two;
      logic [3:0]         phase;
   } rsp_type;

   typedef struct packed {
      logic [1:0] step_one;
      logic [1:0] step_two;
      logic       sw_one_left;
      logic       sw_one_right;
      logic       sw_two_left;
      logic       sw_two_right;
      logic       ms_tick;
   } item_type;

endpackage

// ===== hw/rtl/ths_fifo.sv =====
module ths_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("queue count beyond depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count missed a pop");

endmodule

// ===== hw/rtl/ths_front.sv =====
module ths_front
   import ths_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  req_type  req_data,
   output item_type item
);

   logic [3:0] prev_ff, prev_in;

   function automatic logic [1:0] quad_step(input logic pa, input logic pb,
                                            input logic a, input logic b);
      logic [1:0] step;
      step = STEP_NONE;
      if (pa != a && pb == b) begin
         step = (a != b) ? STEP_UP : STEP_DOWN;
      end else if (pa == a && pb != b) begin
         step = (a != b) ? STEP_DOWN : STEP_UP;
      end
      return step;
   endfunction

   assign prev_in = {req_data.enc_two_b, req_data.enc_two_a,
                     req_data.enc_one_b, req_data.enc_one_a};

   always_comb begin
      item.step_one     = quad_step(prev_ff[0], prev_ff[1],
                                    req_data.enc_one_a, req_data.enc_one_b);
      item.step_two     = quad_step(prev_ff[2], prev_ff[3],
                                    req_data.enc_two_a, req_data.enc_two_b);
      item.sw_one_left  = req_data.sw_one_left;
      item.sw_one_right = req_data.sw_one_right;
      item.sw_two_left  = req_data.sw_two_left;
      item.sw_two_right = req_data.sw_two_right;
      item.ms_tick      = req_data.ms_tick;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (accept) begin
         prev_ff <= prev_in;
      end
   end

endmodule

// ===== hw/rtl/ths_back.sv =====
module ths_back
   import ths_pkg::*;
#(
   parameter int COUNT_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      item_valid,
   input  item_type                  item,
   output logic                      item_pop,
   input  logic                      result_full,
   output logic                      result_push,
   output rsp_type                   result
);

   logic [13:0] drive_duty_ff;
   logic [15:0] dwell_ticks_ff;
   logic [15:0] restart_ticks_ff;
   logic [15:0] offset_two_ff;
   logic [15:0] offset_one_ff;

   logic [COUNT_BITS-1:0] pos_one_ff, pos_one_in;
   logic [COUNT_BITS-1:0] pos_two_ff, pos_two_in;
   logic [COUNT_BITS-1:0] travel_one_ff, travel_one_in;
   logic [COUNT_BITS-1:0] travel_two_ff, travel_two_in;
   logic [COUNT_BITS-1:0] middle_one_ff, middle_one_in;
   logic [COUNT_BITS-1:0] middle_two_ff, middle_two_in;
   logic [3:0]            phase_ff, phase_in;
   logic [15:0]           timer_ff, timer_in;

   logic                  fire;
   logic                  ax_two;
   logic [2:0]            sub;
   logic [COUNT_BITS-1:0] sel_pos;
   logic [COUNT_BITS-1:0] sel_mid_mag;
   logic [COUNT_BITS-1:0] sel_off;
   logic                  sel_sw_l;
   logic                  sel_sw_r;
   logic [15:0]           limit;
   logic                  timer_done;
   logic                  go;

   logic                  out_valid;
   logic                  out_ax_two;
   logic [2:0]            out_sub;
   logic                  dir_right;
   logic                  moving;
   logic [13:0]           duty;

   function automatic logic [COUNT_BITS-1:0] mag_of(input logic [COUNT_BITS-1:0] v);
      return v[COUNT_BITS-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [COUNT_BITS-1:0] halve(input logic [COUNT_BITS-1:0] v);
      logic [COUNT_BITS-1:0] half_mag;
      half_mag = mag_of(v) >> 1;
      return v[COUNT_BITS-1] ? (~half_mag + 1'b1) : (v >> 1);
   endfunction

   function automatic logic [COUNT_BITS-1:0] apply_step(input logic [COUNT_BITS-1:0] v,
                                                        input logic [1:0] step);
      logic [COUNT_BITS-1:0] r;
      case (step)
         STEP_UP:   r = v + 1'b1;
         STEP_DOWN: r = v - 1'b1;
         default:   r = v;
      endcase
      return r;
   endfunction

   assign fire        = item_valid && !result_full;
   assign item_pop    = fire;
   assign result_push = fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_duty_ff    <= DRIVE_DUTY_RESET;
         dwell_ticks_ff   <= DWELL_TICKS_RESET;
         restart_ticks_ff <= RESTART_TICKS_RESET;
         offset_two_ff    <= OFFSET_TWO_RESET;
         offset_one_ff    <= OFFSET_ONE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DRIVE_DUTY:    drive_duty_ff    <= csr_wdata[13:0];
            CSR_DWELL_TICKS:   dwell_ticks_ff   <= csr_wdata;
            CSR_RESTART_TICKS: restart_ticks_ff <= csr_wdata;
            CSR_OFFSET_TWO:    offset_two_ff    <= csr_wdata;
            CSR_OFFSET_ONE:    offset_one_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      pos_one_in    = apply_step(pos_one_ff, item.step_one);
      pos_two_in    = apply_step(pos_two_ff, item.step_two);
      travel_one_in = travel_one_ff;
      travel_two_in = travel_two_ff;
      middle_one_in = middle_one_ff;
      middle_two_in = middle_two_ff;
      phase_in      = phase_ff;
      timer_in      = timer_ff;

      ax_two      = (phase_ff < PH_AXIS_SPAN);
      sub         = ax_two ? phase_ff[2:0] : 3'(phase_ff - PH_AXIS_SPAN);
      sel_pos     = ax_two ? pos_two_in : pos_one_in;
      sel_mid_mag = mag_of(ax_two ? middle_two_ff : middle_one_ff);
      sel_off     = COUNT_BITS'(ax_two ? offset_two_ff : offset_one_ff);
      sel_sw_l    = ax_two ? item.sw_two_left : item.sw_one_left;
      sel_sw_r    = ax_two ? item.sw_two_right : item.sw_one_right;
      limit       = (phase_ff == PH_RESTART) ? restart_ticks_ff : dwell_ticks_ff;
      timer_done  = (timer_ff >= limit);
      go          = (sel_mid_mag > sel_off) && (mag_of(sel_pos) < sel_mid_mag - sel_off)
                    && sel_sw_l;

      if (phase_ff < PH_RESTART) begin
         case (sub)
            SUB_SEEK_LEFT: begin
               if (!sel_sw_l) begin
                  if (ax_two) begin
                     pos_two_in    = '0;
                     travel_two_in = '0;
                  end else begin
                     pos_one_in    = '0;
                     travel_one_in = '0;
                  end
                  timer_in = '0;
                  phase_in = phase_ff + 1'b1;
               end
            end
            SUB_SEEK_RIGHT: begin
               if (!sel_sw_r) begin
                  if (ax_two) begin
                     travel_two_in = sel_pos;
                     middle_two_in = halve(sel_pos);
                  end else begin
                     travel_one_in = sel_pos;
                     middle_one_in = halve(sel_pos);
                  end
                  timer_in = '0;
                  phase_in = phase_ff + 1'b1;
               end
            end
            SUB_CENTER: begin
               if (!go) begin
                  timer_in = '0;
                  phase_in = phase_ff + 1'b1;
               end
            end
            default: begin
               if (timer_done) begin
                  timer_in = '0;
                  phase_in = phase_ff + 1'b1;
                  if (sub == SUB_DWELL_RIGHT) begin
                     if (ax_two) begin
                        pos_two_in = '0;
                     end else begin
                        pos_one_in = '0;
                     end
                  end else if (sub == SUB_DWELL_CENTER && ax_two) begin
                     pos_one_in = '0;
                  end
               end else if (item.ms_tick) begin
                  timer_in = timer_ff + 16'd1;
               end
            end
         endcase
      end else if (phase_ff == PH_RESTART) begin
         if (timer_done) begin
            timer_in   = '0;
            pos_two_in = '0;
            phase_in   = PH_SEEK_LEFT_TWO;
         end else if (item.ms_tick) begin
            timer_in = timer_ff + 16'd1;
         end
      end else begin
         timer_in = '0;
         phase_in = PH_SEEK_LEFT_TWO;
      end
   end

   // direction and drive follow the phase after this step
   always_comb begin
      out_valid = (phase_in <= PH_RESTART);
      if (phase_in == PH_RESTART) begin
         out_ax_two = 1'b0;
         out_sub    = SUB_DWELL_CENTER;
      end else if (phase_in < PH_AXIS_SPAN) begin
         out_ax_two = 1'b1;
         out_sub    = phase_in[2:0];
      end else begin
         out_ax_two = 1'b0;
         out_sub    = 3'(phase_in - PH_AXIS_SPAN);
      end
      dir_right = (out_sub inside {SUB_SEEK_RIGHT, SUB_DWELL_RIGHT});
      moving    = out_valid && (out_sub inside {SUB_SEEK_LEFT, SUB_SEEK_RIGHT, SUB_CENTER});
      duty      = (drive_duty_ff > DUTY_MAX) ? DUTY_MAX : drive_duty_ff;

      result.bridge_one_in1 = out_valid && !out_ax_two && dir_right;
      result.bridge_one_in2 = out_valid && !out_ax_two && !dir_right;
      result.bridge_two_in1 = out_valid && out_ax_two && dir_right;
      result.bridge_two_in2 = out_valid && out_ax_two && !dir_right;
      result.duty_one       = (moving && !out_ax_two) ? duty : '0;
      result.duty_two       = (moving && out_ax_two) ? duty : '0;
      result.count_one      = 32'(signed'(pos_one_in));
      result.count_two      = 32'(signed'(pos_two_in));
      result.span_one       = 32'(signed'(travel_one_in));
      result.span_two       = 32'(signed'(travel_two_in));
      result.phase          = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_one_ff    <= '0;
         pos_two_ff    <= '0;
         travel_one_ff <= '0;
         travel_two_ff <= '0;
         middle_one_ff <= '0;
         middle_two_ff <= '0;
         phase_ff      <= PH_SEEK_LEFT_TWO;
         timer_ff      <= '0;
      end else if (fire) begin
         pos_one_ff    <= pos_one_in;
         pos_two_ff    <= pos_two_in;
         travel_one_ff <= travel_one_in;
         travel_two_ff <= travel_two_in;
         middle_one_ff <= middle_one_in;
         middle_two_ff <= middle_two_in;
         phase_ff      <= phase_in;
         timer_ff      <= timer_in;
      end
   end

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_RESTART)
      else $error("sequencer left its phase range");

   a_timer_idle_in_moves: assert property (@(posedge clock) disable iff (reset)
      (phase_ff < PH_RESTART && (sub == SUB_SEEK_LEFT || sub == SUB_SEEK_RIGHT ||
                                 sub == SUB_CENTER)) |-> timer_ff == '0)
      else $error("wait timer running during a move");

   a_one_axis_driven: assert property (@(posedge clock) disable iff (reset)
      !(result.duty_one != '0 && result.duty_two != '0))
      else $error("both axes driven at once");

endmodule

// ===== hw/rtl/two_axis_homing_sequencer_top.sv =====
// two-axis homing sequencer with x4 quadrature counting
// request side: req_data carries one sample of encoder lines, limit
//   switches and the ms tick; it is taken at an edge with req_push high
//   and req_full low
// response side: one response per request, in order; rsp_data is valid
//   while rsp_empty is low and is taken at an edge with rsp_pop high
// csr side: csr_wr_en writes csr_wdata to register csr_index at once;
//   write only while no request is in flight
// latency: a request taken at edge n is visible on rsp_data after edge
//   n + 1; throughput one request per cycle, set by the single-cycle
//   sequencer step in the back end
// reset clears both queues, counts, spans and phase, and loads the
//   register defaults
// a stalled response side fills the response queue, which stops the
//   back end; the request queue then fills and req_full rises
module two_axis_homing_sequencer_top
   import ths_pkg::*;
#(
   parameter int COUNT_BITS  = 32,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  req_type                   req_data,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output rsp_type                   rsp_data,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic     req_accept;
   item_type front_item;
   item_type back_item;
   logic     item_empty;
   logic     item_pop;
   logic     result_full;
   logic     result_push;
   rsp_type  result;

   assign req_accept = req_push && !req_full;

   ths_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .req_data (req_data),
      .item     (front_item)
   );

   ths_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_item_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (front_item),
      .full  (req_full),
      .pop   (item_pop),
      .rdata (back_item),
      .empty (item_empty)
   );

   ths_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .item_valid  (!item_empty),
      .item        (back_item),
      .item_pop    (item_pop),
      .result_full (result_full),
      .result_push (result_push),
      .result      (result)
   );

   ths_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (result_push),
      .wdata (result),
      .full  (result_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import ths_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int NUM_ROWS    = 22;
   localparam int KNOWN_ROWS  = 3;
   localparam int CFG_ROW     = 3;
   localparam int NUM_PHASES  = 8;
   localparam int PHASE_ITEMS = 160;

   typedef struct packed {
      logic [15:0] duty;
      logic [15:0] dwell;
      logic [15:0] restart;
      logic [15:0] off_two;
      logic [15:0] off_one;
   } cfg_set_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_push;
   logic                      req_full;
   req_type                   req_data;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   // model of the sequencer, index 0 is axis one and index 1 is axis two
   logic [3:0]  lvl_q;
   logic [31:0] cnt_q [2];
   logic [31:0] span_q [2];
   logic [31:0] mid_q [2];
   logic [3:0]  phase_q;
   logic [15:0] timer_q;
   logic [13:0] duty_q;
   logic [15:0] dwell_q;
   logic [15:0] restart_q;
   logic [15:0] off_q [2];

   rsp_type     expected_outputs [$];
   req_type     samples [NUM_ROWS];
   rsp_type     known_rsp [KNOWN_ROWS];
   cfg_set_type cfg_sets [6];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          pop_stall_pct = 0;

   two_axis_homing_sequencer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic [31:0] quad_step(logic [31:0] pos, logic pa, logic pb,
                                             logic a, logic b);
      if (pa != a && pb == b)
         return (a != b) ? pos + 32'd1 : pos - 32'd1;
      if (pa == a && pb != b)
         return (a != b) ? pos - 32'd1 : pos + 32'd1;
      return pos;
   endfunction

   function automatic logic [31:0] mag(logic [31:0] v);
      return v[31] ? -v : v;
   endfunction

   function automatic logic [31:0] halve(logic [31:0] v);
      return v[31] ? -(mag(v) >> 1) : v >> 1;
   endfunction

   function automatic bit timer_expired(logic [15:0] limit, logic tick);
      if (timer_q >= limit) begin
         timer_q = '0;
         return 1'b1;
      end
      if (tick)
         timer_q = timer_q + 16'd1;
      return 1'b0;
   endfunction

   function automatic logic [2:0] sub_of(logic [3:0] p);
      logic [3:0] rel;
      rel = (p < PH_AXIS_SPAN) ? p : p - PH_AXIS_SPAN;
      return rel[2:0];
   endfunction

   function automatic rsp_type homing_step(req_type s);
      rsp_type     r;
      logic [3:0]  nxt;
      logic [2:0]  sub;
      logic [31:0] m;
      logic [1:0]  sw_l;
      logic [1:0]  sw_r;
      logic [1:0]  in1;
      logic [1:0]  in2;
      logic [1:0]  mov;
      logic [13:0] duty;
      int          ax;
      bit          go;
      cnt_q[0] = quad_step(cnt_q[0], lvl_q[0], lvl_q[1], s.enc_one_a, s.enc_one_b);
      cnt_q[1] = quad_step(cnt_q[1], lvl_q[2], lvl_q[3], s.enc_two_a, s.enc_two_b);
      lvl_q = {s.enc_two_b, s.enc_two_a, s.enc_one_b, s.enc_one_a};
      sw_l = {s.sw_two_left, s.sw_one_left};
      sw_r = {s.sw_two_right, s.sw_one_right};
      nxt = phase_q;
      if (phase_q < PH_RESTART) begin
         ax = (phase_q < PH_AXIS_SPAN) ? 1 : 0;
         sub = sub_of(phase_q);
         case (sub)
            SUB_SEEK_LEFT: begin
               if (!sw_l[ax]) begin
                  cnt_q[ax] = '0;
                  span_q[ax] = '0;
                  timer_q = '0;
                  nxt = phase_q + 4'd1;
               end
            end
            SUB_SEEK_RIGHT: begin
               if (!sw_r[ax]) begin
                  span_q[ax] = cnt_q[ax];
                  mid_q[ax] = halve(cnt_q[ax]);
                  timer_q = '0;
                  nxt = phase_q + 4'd1;
               end
            end
            SUB_CENTER: begin
               m = mag(mid_q[ax]);
               go = (m > {16'd0, off_q[ax]}) && (mag(cnt_q[ax]) < m - {16'd0, off_q[ax]})
                    && sw_l[ax];
               if (!go) begin
                  timer_q = '0;
                  nxt = phase_q + 4'd1;
               end
            end
            default: begin
               if (timer_expired(dwell_q, s.ms_tick)) begin
                  nxt = phase_q + 4'd1;
                  if (sub == SUB_DWELL_RIGHT)
                     cnt_q[ax] = '0;
                  else if (sub == SUB_DWELL_CENTER && ax == 1)
                     cnt_q[0] = '0;
               end
            end
         endcase
      end else if (phase_q == PH_RESTART) begin
         if (timer_expired(restart_q, s.ms_tick)) begin
            cnt_q[1] = '0;
            nxt = PH_SEEK_LEFT_TWO;
         end
      end else begin
         timer_q = '0;
         nxt = PH_SEEK_LEFT_TWO;
      end
      phase_q = nxt;

      in1 = '0;
      in2 = '0;
      mov = '0;
      if (phase_q <= PH_RESTART) begin
         if (phase_q == PH_RESTART) begin
            ax = 0;
            sub = SUB_DWELL_CENTER;
         end else begin
            ax = (phase_q < PH_AXIS_SPAN) ? 1 : 0;
            sub = sub_of(phase_q);
         end
         if (sub == SUB_SEEK_RIGHT || sub == SUB_DWELL_RIGHT)
            in1[ax] = 1'b1;
         else
            in2[ax] = 1'b1;
         if (sub == SUB_SEEK_LEFT || sub == SUB_SEEK_RIGHT || sub == SUB_CENTER)
            mov[ax] = 1'b1;
      end
      duty = (duty_q > DUTY_MAX) ? DUTY_MAX : duty_q;

      r.bridge_one_in1 = in1[0];
      r.bridge_one_in2 = in2[0];
      r.bridge_two_in1 = in1[1];
      r.bridge_two_in2 = in2[1];
      r.duty_one = mov[0] ? duty : 14'd0;
      r.duty_two = mov[1] ? duty : 14'd0;
      r.count_one = cnt_q[0];
      r.count_two = cnt_q[1];
      r.span_one = span_q[0];
      r.span_two = span_q[1];
      r.phase = phase_q;
      return r;
   endfunction

   // ab is {a, b}; bias +1 steps up, -1 steps down, 0 either way
   function automatic logic [1:0] next_levels(logic [1:0] ab, int bias);
      int         pick;
      int         dir;
      logic [1:0] nx;
      pick = $urandom_range(15);
      dir = $urandom_range(1) ? 1 : -1;
      if (pick <= 6 && bias != 0)
         dir = bias;
      else if (pick <= 10 && bias != 0)
         dir = -bias;
      nx = ab;
      if (pick == 15) begin
         nx = ~ab;
      end else if (pick <= 10) begin
         if ((ab[1] == ab[0]) == (dir > 0))
            nx = ab ^ 2'b10;
         else
            nx = ab ^ 2'b01;
      end
      return nx;
   endfunction

   function automatic req_type random_sample();
      req_type    s;
      logic [1:0] ab_one;
      logic [1:0] ab_two;
      logic [2:0] sub;
      int         dir;
      int         bias_one;
      int         bias_two;
      bias_one = 0;
      bias_two = 0;
      if (phase_q < PH_RESTART) begin
         sub = sub_of(phase_q);
         dir = 0;
         if (sub == SUB_SEEK_RIGHT)
            dir = 1;
         else if (sub == SUB_SEEK_LEFT || sub == SUB_CENTER)
            dir = -1;
         if (phase_q < PH_AXIS_SPAN)
            bias_two = dir;
         else
            bias_one = dir;
      end
      ab_one = next_levels({lvl_q[0], lvl_q[1]}, bias_one);
      ab_two = next_levels({lvl_q[2], lvl_q[3]}, bias_two);
      s.enc_one_a = ab_one[1];
      s.enc_one_b = ab_one[0];
      s.enc_two_a = ab_two[1];
      s.enc_two_b = ab_two[0];
      s.sw_one_left = ($urandom_range(99) >= 6);
      s.sw_one_right = ($urandom_range(99) >= 6);
      s.sw_two_left = ($urandom_range(99) >= 6);
      s.sw_two_right = ($urandom_range(99) >= 6);
      s.ms_tick = 1'($urandom_range(1));
      return s;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("mismatch %s: got %0h want %0h", what, got, want);
   endtask

   task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch(name, got, want);
   endtask

   task automatic check_response(rsp_type got, rsp_type want);
      compare_field("bridge_one_in1", 32'(got.bridge_one_in1), 32'(want.bridge_one_in1));
      compare_field("bridge_one_in2", 32'(got.bridge_one_in2), 32'(want.bridge_one_in2));
      compare_field("bridge_two_in1", 32'(got.bridge_two_in1), 32'(want.bridge_two_in1));
      compare_field("bridge_two_in2", 32'(got.bridge_two_in2), 32'(want.bridge_two_in2));
      compare_field("duty_one", 32'(got.duty_one), 32'(want.duty_one));
      compare_field("duty_two", 32'(got.duty_two), 32'(want.duty_two));
      compare_field("count_one", got.count_one, want.count_one);
      compare_field("count_two", got.count_two, want.count_two);
      compare_field("span_one", got.span_one, want.span_one);
      compare_field("span_two", got.span_two, want.span_two);
      compare_field("phase", 32'(got.phase), 32'(want.phase));
   endtask

   task automatic send_item(req_type s, bit known, rsp_type known_val);
      rsp_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_push <= 1'b1;
      req_data <= s;
      do
         @(posedge clock);
      while (req_full);
      pred = homing_step(s);
      expected_outputs.push_back(known ? known_val : pred);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_push <= 1'b0;
      while (expected_outputs.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_DRIVE_DUTY:    duty_q = val[13:0];
         CSR_DWELL_TICKS:   dwell_q = val;
         CSR_RESTART_TICKS: restart_q = val;
         CSR_OFFSET_TWO:    off_q[1] = val;
         CSR_OFFSET_ONE:    off_q[0] = val;
         default: ;
      endcase
   endtask

   task automatic apply_settings(cfg_set_type c);
      write_reg(CSR_DRIVE_DUTY, c.duty);
      write_reg(CSR_DWELL_TICKS, c.dwell);
      write_reg(CSR_RESTART_TICKS, c.restart);
      write_reg(CSR_OFFSET_TWO, c.off_two);
      write_reg(CSR_OFFSET_ONE, c.off_one);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   always @(negedge clock)
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);

   always @(posedge clock) begin
      if (!reset && !rsp_empty && rsp_pop) begin
         if (expected_outputs.size() == 0)
            report_mismatch("response without request", 32'(rsp_data.phase), '0);
         else
            check_response(rsp_data, expected_outputs.pop_front());
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int row;
      int ph;
      int n;
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;

      lvl_q = '0;
      cnt_q[0] = '0;
      cnt_q[1] = '0;
      span_q[0] = '0;
      span_q[1] = '0;
      mid_q[0] = '0;
      mid_q[1] = '0;
      phase_q = PH_SEEK_LEFT_TWO;
      timer_q = '0;
      duty_q = DRIVE_DUTY_RESET;
      dwell_q = DWELL_TICKS_RESET;
      restart_q = RESTART_TICKS_RESET;
      off_q[1] = OFFSET_TWO_RESET;
      off_q[0] = OFFSET_ONE_RESET;

      // field order: enc one ab, enc two ab, switches l1 r1 l2 r2, tick
      samples[0]  = 9'b00_00_1111_0;
      samples[1]  = 9'b00_10_1111_0;
      samples[2]  = 9'b00_10_1101_0;
      samples[3]  = 9'b00_10_1111_1;
      samples[4]  = 9'b00_00_1111_0;
      samples[5]  = 9'b00_01_1111_0;
      samples[6]  = 9'b00_11_1111_0;
      samples[7]  = 9'b00_11_1110_0;
      samples[8]  = 9'b00_11_1111_0;
      samples[9]  = 9'b00_11_1111_0;
      samples[10] = 9'b00_11_1111_1;
      samples[11] = 9'b10_11_0111_0;
      samples[12] = 9'b10_11_1111_0;
      samples[13] = 9'b11_11_1111_0;
      samples[14] = 9'b01_11_1111_0;
      samples[15] = 9'b00_11_1011_0;
      samples[16] = 9'b00_11_1111_0;
      samples[17] = 9'b10_11_1111_0;
      samples[18] = 9'b10_11_1111_1;
      samples[19] = 9'b10_11_1111_1;
      samples[20] = 9'b01_00_1111_0;
      samples[21] = 9'b01_00_0000_1;

      // reset defaults: axis two seeking left at default duty
      known_rsp[0] = '0;
      known_rsp[0].bridge_two_in2 = 1'b1;
      known_rsp[0].duty_two = DRIVE_DUTY_RESET;
      known_rsp[0].phase = PH_SEEK_LEFT_TWO;
      known_rsp[1] = known_rsp[0];
      known_rsp[1].count_two = 32'sd1;
      // left switch of axis two closes: count zeroed, dwell, motor off
      known_rsp[2] = known_rsp[0];
      known_rsp[2].duty_two = 14'd0;
      known_rsp[2].phase = PH_SEEK_LEFT_TWO + 4'd1;

      cfg_sets[0] = '{16'd12499, 16'd0, 16'd1, 16'd3, 16'd0};
      cfg_sets[1] = '{16'hFFFF, 16'd2, 16'd3, 16'd0, 16'd0};
      cfg_sets[2] = '{16'd0, 16'd1, 16'd0, 16'hFFFF, 16'hFFFF};
      cfg_sets[3] = '{16'd500, 16'd3, 16'd5, 16'd2, 16'd5};
      cfg_sets[4] = '{16'd12500, 16'hFFFF, 16'hFFFF, 16'd100, 16'd0};
      cfg_sets[5] = '{16'd999, 16'd0, 16'd0, 16'd1, 16'd1};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (row = 0; row < NUM_ROWS; row++) begin
         if (row == CFG_ROW) begin
            wait_idle();
            apply_settings(cfg_sets[0]);
         end
         send_item(samples[row], row < KNOWN_ROWS, known_rsp[row % KNOWN_ROWS]);
      end

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         apply_settings(cfg_sets[1 + ph % 5]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin send_idle_pct = 73; pop_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  pop_stall_pct = 73; end
            default: begin send_idle_pct = 20; pop_stall_pct = 20; end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++)
            send_item(random_sample(), 1'b0, '0);
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_outputs.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/ths_pkg.sv
hw/rtl/ths_fifo.sv
hw/rtl/ths_front.sv
hw/rtl/ths_back.sv
hw/rtl/two_axis_homing_sequencer_top.sv
tb/tb.sv
